>>> hdl/ordered_list_insert_remove_assert.svh
// Assertion macros for the ordered list block and its checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define OLIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OLIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/olir_pkg.sv
// Package for the ordered list block: sizes, mode and status codes, width helpers.
// No dependencies.
`timescale 1ns / 1ps

package olir_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PORT_IDX_W = 5;
    localparam int PORT_CNT_W = 5;
    localparam int PORT_WORD_W = 32;
    localparam int CMP_W  = (CNT_W > PORT_IDX_W) ? CNT_W : PORT_IDX_W;
    localparam int OCW    = (CNT_W > PORT_CNT_W) ? CNT_W : PORT_CNT_W;
    localparam int EXT_W  = (WORD_BITS > PORT_WORD_W) ? WORD_BITS : PORT_WORD_W;

    typedef enum logic [1:0] {
        MD_READ   = 2'd0,
        MD_INSERT = 2'd1,
        MD_APPEND = 2'd2,
        MD_REMOVE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    function automatic logic [WORD_BITS-1:0] word_in(input logic [PORT_WORD_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[WORD_BITS-1:0];
    endfunction

    function automatic logic [PORT_WORD_W-1:0] word_out(input logic [WORD_BITS-1:0] w);
        logic [EXT_W-1:0] e;
        e = EXT_W'(w);
        return e[PORT_WORD_W-1:0];
    endfunction

    function automatic logic [PORT_CNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [OCW-1:0] e;
        e = OCW'(c);
        return e[PORT_CNT_W-1:0];
    endfunction

endpackage

>>> hdl/ordered_list_insert_remove.sv
// Ordered list top level: command sequencer around one entry RAM.
// Depends on olir_pkg and olir_ram.
//
// Usage:
//   A command word (i_mode, i_index, i_value) is taken at a rising edge with
//   start high and busy low. busy stays high while the sequencer walks the
//   list; one result word (o_read_data, o_status, o_entry_count) is shown
//   for exactly one cycle with o_done high. The receiver cannot stall.
//   Command flow: append, and any command rejected up front, finish straight
//   from idle; a read in range waits for the RAM read; an insert at index k
//   moves each entry from the end down to k up one place, then writes the
//   new value at k; a remove compares entries from the head until a match,
//   then shifts each later entry down one place, or reports not found after
//   the last entry.
//   Each move or compare is one RAM read, then a write or a compare,
//   through the single registered read port of the entry RAM.
//   busy drops in the cycle o_done is high, so the next command may be
//   taken while the result is still shown.
//   Reset empties the list (count zero); RAM contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_insert_remove (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_index,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INS_RD,
        S_INS_WR,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR
    } t_state;

    t_state                            r_state;
    logic [olir_pkg::CNT_W-1:0]        r_count;
    logic [olir_pkg::CNT_W-1:0]        r_ptr;
    logic [olir_pkg::CNT_W-1:0]        r_idx;
    logic [olir_pkg::WORD_BITS-1:0]    r_val;
    logic                              r_done;
    logic [31:0]                       r_rdata;
    olir_pkg::t_status                 r_status;
    logic [4:0]                        r_ecount;

    logic                              ram_we;
    logic [olir_pkg::IDX_W-1:0]        ram_waddr;
    logic [olir_pkg::WORD_BITS-1:0]    ram_wdata;
    logic                              ram_re;
    logic [olir_pkg::IDX_W-1:0]        ram_raddr;
    logic [olir_pkg::WORD_BITS-1:0]    ram_rdata;

    logic [olir_pkg::CMP_W-1:0]        idx_ext;
    logic [olir_pkg::CMP_W-1:0]        cnt_ext;
    logic [olir_pkg::CNT_W-1:0]        ptr_inc;
    logic [olir_pkg::CNT_W-1:0]        ptr_dec;
    logic [olir_pkg::CNT_W-1:0]        cnt_inc;
    logic [olir_pkg::CNT_W-1:0]        cnt_dec;
    logic                              full;
    olir_pkg::t_mode                   mode;

    assign mode    = olir_pkg::t_mode'(i_mode);
    assign idx_ext = olir_pkg::CMP_W'(i_index);
    assign cnt_ext = olir_pkg::CMP_W'(r_count);
    assign ptr_inc = r_ptr + 1'b1;
    assign ptr_dec = r_ptr - 1'b1;
    assign cnt_inc = r_count + 1'b1;
    assign cnt_dec = r_count - 1'b1;
    assign full    = (r_count == olir_pkg::CNT_W'(olir_pkg::CAPACITY));

    olir_ram #(
        .WIDTH (olir_pkg::WORD_BITS),
        .DEPTH (olir_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && mode == olir_pkg::MD_READ) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_ext[olir_pkg::IDX_W-1:0];
                end
                if (start && mode == olir_pkg::MD_APPEND && !full) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[olir_pkg::IDX_W-1:0];
                    ram_wdata = olir_pkg::word_in(i_value);
                end
            end
            S_RD_WAIT: ;
            S_INS_RD: begin
                if (r_ptr > r_idx) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_dec[olir_pkg::IDX_W-1:0];
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[olir_pkg::IDX_W-1:0];
                end
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[olir_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            S_RM_RD: begin
                if (r_ptr != r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_ptr[olir_pkg::IDX_W-1:0];
                end
            end
            S_RM_CMP: ;
            S_SH_RD: begin
                if (ptr_inc < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[olir_pkg::IDX_W-1:0];
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[olir_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_idx   <= idx_ext[olir_pkg::CNT_W-1:0];
                        r_val   <= olir_pkg::word_in(i_value);
                        r_rdata <= '0;
                        unique case (mode)
                            olir_pkg::MD_READ: begin
                                if (idx_ext < cnt_ext) begin
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_status <= olir_pkg::ST_RANGE;
                                    r_ecount <= olir_pkg::cnt_out(r_count);
                                end
                            end
                            olir_pkg::MD_INSERT: begin
                                if (idx_ext > cnt_ext) begin
                                    r_done   <= 1'b1;
                                    r_status <= olir_pkg::ST_RANGE;
                                    r_ecount <= olir_pkg::cnt_out(r_count);
                                end else if (full) begin
                                    r_done   <= 1'b1;
                                    r_status <= olir_pkg::ST_FULL;
                                    r_ecount <= olir_pkg::cnt_out(r_count);
                                end else begin
                                    r_ptr   <= r_count;
                                    r_state <= S_INS_RD;
                                end
                            end
                            olir_pkg::MD_APPEND: begin
                                r_done <= 1'b1;
                                if (full) begin
                                    r_status <= olir_pkg::ST_FULL;
                                    r_ecount <= olir_pkg::cnt_out(r_count);
                                end else begin
                                    r_count  <= cnt_inc;
                                    r_status <= olir_pkg::ST_OK;
                                    r_ecount <= olir_pkg::cnt_out(cnt_inc);
                                end
                            end
                            olir_pkg::MD_REMOVE: begin
                                r_ptr   <= '0;
                                r_state <= S_RM_RD;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_done   <= 1'b1;
                    r_rdata  <= olir_pkg::word_out(ram_rdata);
                    r_status <= olir_pkg::ST_OK;
                    r_ecount <= olir_pkg::cnt_out(r_count);
                    r_state  <= S_IDLE;
                end
                S_INS_RD: begin
                    if (r_ptr > r_idx) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count  <= cnt_inc;
                        r_done   <= 1'b1;
                        r_status <= olir_pkg::ST_OK;
                        r_ecount <= olir_pkg::cnt_out(cnt_inc);
                        r_state  <= S_IDLE;
                    end
                end
                S_INS_WR: begin
                    r_ptr   <= ptr_dec;
                    r_state <= S_INS_RD;
                end
                S_RM_RD: begin
                    if (r_ptr == r_count) begin
                        r_done   <= 1'b1;
                        r_status <= olir_pkg::ST_NOTFOUND;
                        r_ecount <= olir_pkg::cnt_out(r_count);
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_RM_CMP;
                    end
                end
                S_RM_CMP: begin
                    if (ram_rdata == r_val) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_ptr   <= ptr_inc;
                        r_state <= S_RM_RD;
                    end
                end
                S_SH_RD: begin
                    if (ptr_inc < r_count) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_count  <= cnt_dec;
                        r_done   <= 1'b1;
                        r_status <= olir_pkg::ST_OK;
                        r_ecount <= olir_pkg::cnt_out(cnt_dec);
                        r_state  <= S_IDLE;
                    end
                end
                S_SH_WR: begin
                    r_ptr   <= ptr_inc;
                    r_state <= S_SH_RD;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_read_data   = r_rdata;
    assign o_status      = r_status;
    assign o_entry_count = r_ecount;

endmodule

>>> hdl/olir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module olir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/olir_checker.sv
// Port-level checker for the ordered list block, bound to the top level.
// Depends on olir_pkg and ordered_list_insert_remove_assert.svh.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_assert.svh"

module olir_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_read_data,
    input logic [1:0]  o_status,
    input logic [4:0]  o_entry_count
);

    `OLIR_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "accepted word made no progress")
    `OLIR_ASSERT_NOW(a_fail_zero_data, o_done && o_status != olir_pkg::ST_OK, o_read_data == 32'd0, "failed command returned data")
    `OLIR_ASSERT_NOW(a_full_count, o_done && o_status == olir_pkg::ST_FULL, o_entry_count == olir_pkg::cnt_out(olir_pkg::CNT_W'(olir_pkg::CAPACITY)), "full status with list not full")
    `OLIR_ASSERT_NOW(a_busy_no_done, $rose(busy), !o_done, "result strobed as a long command started")

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_read_data   (o_read_data),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

>>> dv/ordered_list_checker.sv
// Scoreboard for the ordered list block: watches the command and result ports,
// predicts each result word from its own copy of the list and compares it field by field.
// Depends on olir_pkg.
`timescale 1ns / 1ps

module ordered_list_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_index,
    input  logic [31:0] i_value,
    input  logic        i_done,
    input  logic [31:0] i_read_data,
    input  logic [1:0]  i_status,
    input  logic [4:0]  i_entry_count,
    output int          o_mismatches,
    output int          o_owed
);

    typedef struct {
        olir_pkg::t_mode   mode;
        logic [31:0]       read_data;
        olir_pkg::t_status status;
        logic [4:0]        entry_count;
    } t_list_result;

    logic [31:0]  held[$];
    t_list_result owed_q[$];

    task automatic report(input string msg);
        o_mismatches++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // applies one command to the shadow list and returns the result word it gives
    function automatic t_list_result apply_command(input olir_pkg::t_mode m,
                                                   input logic [4:0] idx,
                                                   input logic [31:0] v);
        t_list_result r;
        int           pos;
        r.mode      = m;
        r.read_data = '0;
        r.status    = olir_pkg::ST_OK;
        pos         = -1;
        unique case (m)
            olir_pkg::MD_READ: begin
                if (idx < held.size()) r.read_data = held[idx];
                else r.status = olir_pkg::ST_RANGE;
            end
            olir_pkg::MD_INSERT: begin
                if (idx > held.size()) r.status = olir_pkg::ST_RANGE;
                else if (held.size() >= olir_pkg::CAPACITY) r.status = olir_pkg::ST_FULL;
                else held.insert(idx, v);
            end
            olir_pkg::MD_APPEND: begin
                if (held.size() >= olir_pkg::CAPACITY) r.status = olir_pkg::ST_FULL;
                else held.push_back(v);
            end
            olir_pkg::MD_REMOVE: begin
                for (int i = 0; i < held.size() && pos < 0; i++) begin
                    if (held[i] == v) pos = i;
                end
                if (pos < 0) r.status = olir_pkg::ST_NOTFOUND;
                else held.delete(pos);
            end
        endcase
        r.entry_count = 5'(held.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            held.delete();
            owed_q.delete();
        end else begin
            if (i_done) begin
                if (owed_q.size() == 0) begin
                    report($sformatf("unexpected result word: data %h status %0d count %0d",
                                     i_read_data, i_status, i_entry_count));
                end else begin
                    want = owed_q.pop_front();
                    if (i_read_data !== want.read_data)
                        report($sformatf("mode %0d read_data %h, want %h",
                                         want.mode, i_read_data, want.read_data));
                    if (i_status !== want.status)
                        report($sformatf("mode %0d status %0d, want %0d",
                                         want.mode, i_status, want.status));
                    if (i_entry_count !== want.entry_count)
                        report($sformatf("mode %0d entry_count %0d, want %0d",
                                         want.mode, i_entry_count, want.entry_count));
                end
            end
            if (i_start && !i_busy)
                owed_q.push_back(apply_command(olir_pkg::t_mode'(i_mode), i_index, i_value));
        end
        o_owed <= owed_q.size();
    end

endmodule

>>> dv/tb_top.sv
// Top of the ordered list testbench: clock, reset, command stimulus and the verdict.
// Depends on olir_pkg, ordered_list_insert_remove and ordered_list_checker.
`timescale 1ns / 1ps

module tb_top;

    // limit allows for the longest remove plus the longest gap on every word
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 1900;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  i_mode  = '0;
    logic [4:0]  i_index = '0;
    logic [31:0] i_value = '0;
    logic        busy;
    logic        o_done;
    logic [31:0] o_read_data;
    logic [1:0]  o_status;
    logic [4:0]  o_entry_count;

    int          mismatches;
    int          results_owed;
    int          cycles       = 0;
    int          back_to_back = 0;
    logic [4:0]  seen_count   = '0;

    ordered_list_insert_remove uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    ordered_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_done        (o_done),
        .i_read_data   (o_read_data),
        .i_status      (o_status),
        .i_entry_count (o_entry_count),
        .o_mismatches  (mismatches),
        .o_owed        (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // fill level as last reported, used only to steer stimulus
    always @(posedge i_clk) begin
        if (o_done) seen_count <= o_entry_count;
    end

    task automatic issue(input olir_pkg::t_mode m, input logic [4:0] idx,
                         input logic [31:0] v);
        start   <= 1'b1;
        i_mode  <= m;
        i_index <= idx;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        if (back_to_back > 0) begin
            back_to_back--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            back_to_back = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // small pool so removes hit and duplicates occur
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom();
            default: return 32'($urandom_range(0, 7));
        endcase
    endfunction

    initial begin
        olir_pkg::t_mode m;
        logic [4:0]      idx;
        int              r;
        bit              growing;
        growing = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        issue(olir_pkg::MD_READ, 5'd0, 32'h0);
        issue(olir_pkg::MD_REMOVE, 5'd0, 32'h0);
        issue(olir_pkg::MD_INSERT, 5'd1, 32'h1);
        // insert at head, middle and end
        issue(olir_pkg::MD_INSERT, 5'd0, 32'hFFFF_FFFF);
        issue(olir_pkg::MD_APPEND, 5'd31, 32'h0);
        issue(olir_pkg::MD_INSERT, 5'd1, 32'hA5A5_A5A5);
        issue(olir_pkg::MD_INSERT, 5'd3, 32'h0000_0001);
        issue(olir_pkg::MD_READ, 5'd31, 32'h0);
        issue(olir_pkg::MD_READ, 5'd3, 32'hFFFF_FFFF);
        issue(olir_pkg::MD_REMOVE, 5'd0, 32'hA5A5_A5A5);
        issue(olir_pkg::MD_REMOVE, 5'd0, 32'h1234_5678);
        // fill to capacity with duplicates
        for (int k = 0; k < 13; k++)
            issue(olir_pkg::MD_APPEND, 5'd0, k[0] ? 32'h0 : $urandom());
        issue(olir_pkg::MD_APPEND, 5'd0, 32'h5A5A_5A5A);
        issue(olir_pkg::MD_INSERT, 5'd16, 32'h1);
        issue(olir_pkg::MD_INSERT, 5'd17, 32'h1);
        issue(olir_pkg::MD_READ, 5'd15, 32'h0);
        issue(olir_pkg::MD_READ, 5'd16, 32'h0);
        issue(olir_pkg::MD_REMOVE, 5'd10, 32'h0);
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (seen_count >= olir_pkg::CAPACITY && $urandom_range(0, 3) == 0) growing = 1'b0;
            else if (seen_count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
            else if ($urandom_range(0, 59) == 0) growing = !growing;
            r = $urandom_range(0, 99);
            if (growing)
                m = (r < 35) ? olir_pkg::MD_APPEND :
                    (r < 65) ? olir_pkg::MD_INSERT :
                    (r < 80) ? olir_pkg::MD_READ : olir_pkg::MD_REMOVE;
            else
                m = (r < 10) ? olir_pkg::MD_APPEND :
                    (r < 20) ? olir_pkg::MD_INSERT :
                    (r < 40) ? olir_pkg::MD_READ : olir_pkg::MD_REMOVE;
            if ($urandom_range(0, 7) == 0) idx = 5'($urandom_range(0, 31));
            else if (m == olir_pkg::MD_INSERT) idx = 5'($urandom_range(0, seen_count));
            else if (seen_count == 0) idx = 5'd0;
            else idx = 5'($urandom_range(0, seen_count - 1));
            issue(m, idx, pick_value());
            if (n % 400 == 399) drain();
            else idle(pick_gap());
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
